[design/ppte_pkg.sv]
package ppte_pkg;

    localparam int DEF_MAX_INTERVALS = 256;
    localparam int DEF_MAX_TERMS     = 8;

    // request kinds carried in tuser
    localparam logic [1:0] REQ_EVAL  = 2'd0;
    localparam logic [1:0] REQ_COEF  = 2'd1;
    localparam logic [1:0] REQ_START = 2'd2;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_RANGE_START    = 3'd0;
    localparam logic [2:0] REG_CUTOFF         = 3'd1;
    localparam logic [2:0] REG_INV_WIDTH      = 3'd2;
    localparam logic [2:0] REG_TERM_COUNT     = 3'd3;
    localparam logic [2:0] REG_INTERVAL_COUNT = 3'd4;

    localparam logic signed [63:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] SAT_LO = 64'shFFFF_FFFF_8000_0000;

    typedef logic signed [31:0] t_q;

    typedef struct packed {
        t_q          range_start;
        t_q          cutoff;
        logic [31:0] inv_width;
        logic [3:0]  term_count;
        logic [8:0]  interval_count;
    } t_cfg;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] slot;
        logic [2:0] term;
        t_q         opnd;
    } t_req;

    // item as it moves along the coefficient cells
    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] term;
        logic       wr_ok;
        logic       beyond;
        logic       clamped;
        t_q         arg;    // offset x for evaluate, load word otherwise
        t_q         v;
        t_q         d;
    } t_item;

    // saturate a wide signed value to q16.16
    function automatic t_q sat64(input logic signed [63:0] val);
        if (val > SAT_HI) begin
            return SAT_HI[31:0];
        end else if (val < SAT_LO) begin
            return SAT_LO[31:0];
        end
        return val[31:0];
    endfunction

endpackage

[design/ppte_front.sv]
module ppte_front import ppte_pkg::*; #(
    parameter int MAX_INTERVALS = DEF_MAX_INTERVALS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  t_cfg                                i_cfg,
    input  logic                                i_valid,
    input  t_req                                i_req,
    output logic                                o_ready,
    output logic                                o_valid,
    output t_item                               o_item,
    output logic [$clog2(MAX_INTERVALS)-1:0]    o_addr,
    input  logic                                i_ready
);

    localparam int IDX_W  = $clog2(MAX_INTERVALS);
    localparam int NINT_W = $clog2(MAX_INTERVALS + 1);

    logic                r0_vld, r1_vld, r2_vld, r3_vld, r4_vld;
    logic                rdy0, rdy1, rdy2, rdy3, rdy4;
    t_req                r0_req, r1_req, r2_req, r3_req;
    logic signed [32:0]  r0_diff;
    logic                r0_beyond, r1_beyond, r2_beyond, r3_beyond;
    logic                r1_neg, r2_neg;
    logic [31:0]         r1_mag;
    logic [63:0]         r2_prod;
    logic                r3_clamped, r3_wr_ok;
    logic [IDX_W-1:0]    r3_addr, r4_addr;
    t_q                  r_start;
    t_item               r4_item;
    t_q                  r_start_mem [MAX_INTERVALS];

    logic [NINT_W-1:0]   nint;
    logic signed [32:0]  n0_diff;
    logic                n0_beyond;
    logic                n1_neg;
    logic [31:0]         n1_mag;
    logic [31:0]         hi;
    logic [IDX_W-1:0]    n3_addr;
    logic                n3_clamped, n3_wr_ok, wr_start;
    t_item               n4_item;

    assign rdy4    = !r4_vld || i_ready;
    assign rdy3    = !r3_vld || rdy4;
    assign rdy2    = !r2_vld || rdy3;
    assign rdy1    = !r1_vld || rdy2;
    assign rdy0    = !r0_vld || rdy1;
    assign o_ready = rdy0;

    // intervals in use, kept within the store
    always_comb begin
        if (i_cfg.interval_count == 9'd0) begin
            nint = NINT_W'(1);
        end else if (32'(i_cfg.interval_count) > 32'(MAX_INTERVALS)) begin
            nint = NINT_W'(MAX_INTERVALS);
        end else begin
            nint = NINT_W'(i_cfg.interval_count);
        end
    end

    assign n0_diff   = 33'($signed(i_req.opnd)) - 33'($signed(i_cfg.range_start));
    assign n0_beyond = (i_req.kind == REQ_EVAL) &&
                       ($signed(i_req.opnd) > $signed(i_cfg.cutoff));

    assign n1_neg = r0_diff[32];
    assign n1_mag = r0_diff[32] ? 32'(-r0_diff) : r0_diff[31:0];

    // interval lookup and clamp
    assign hi = r2_prod[63:32];
    always_comb begin
        n3_wr_ok   = 32'(r2_req.slot) < 32'(MAX_INTERVALS);
        n3_clamped = 1'b0;
        if (r2_req.kind != REQ_EVAL) begin
            n3_addr = IDX_W'(r2_req.slot);
        end else if (r2_neg && (r2_prod != 64'd0)) begin
            n3_addr    = '0;
            n3_clamped = !r2_beyond;
        end else if (hi >= 32'(nint)) begin
            n3_addr    = IDX_W'(nint - NINT_W'(1));
            n3_clamped = !r2_beyond;
        end else begin
            n3_addr = hi[IDX_W-1:0];
        end
    end

    assign wr_start = r2_vld && rdy3 && (r2_req.kind == REQ_START) && n3_wr_ok;

    always_comb begin
        n4_item.kind    = r3_req.kind;
        n4_item.term    = r3_req.term;
        n4_item.wr_ok   = r3_wr_ok;
        n4_item.beyond  = r3_beyond;
        n4_item.clamped = r3_clamped;
        n4_item.v       = '0;
        n4_item.d       = '0;
        if (r3_req.kind == REQ_EVAL) begin
            n4_item.arg = sat64(64'($signed(r3_req.opnd)) - 64'($signed(r_start)));
        end else begin
            n4_item.arg = r3_req.opnd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else begin
            if (rdy0) r0_vld <= i_valid;
            if (rdy1) r1_vld <= r0_vld;
            if (rdy2) r2_vld <= r1_vld;
            if (rdy3) r3_vld <= r2_vld;
            if (rdy4) r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy0) begin
            r0_req    <= i_req;
            r0_diff   <= n0_diff;
            r0_beyond <= n0_beyond;
        end
        if (rdy1) begin
            r1_req    <= r0_req;
            r1_beyond <= r0_beyond;
            r1_neg    <= n1_neg;
            r1_mag    <= n1_mag;
        end
        if (rdy2) begin
            r2_req    <= r1_req;
            r2_beyond <= r1_beyond;
            r2_neg    <= r1_neg;
            r2_prod   <= 64'(r1_mag) * 64'(i_cfg.inv_width);
        end
        if (rdy3) begin
            r3_req     <= r2_req;
            r3_beyond  <= r2_beyond;
            r3_clamped <= n3_clamped;
            r3_wr_ok   <= n3_wr_ok;
            r3_addr    <= n3_addr;
        end
        if (rdy4) begin
            r4_item <= n4_item;
            r4_addr <= r3_addr;
        end
    end

    // interval start store
    always_ff @(posedge i_clk) begin
        if (wr_start) r_start_mem[n3_addr] <= r2_req.opnd;
        if (rdy3) r_start <= r_start_mem[n3_addr];
    end

    assign o_valid = r4_vld;
    assign o_item  = r4_item;
    assign o_addr  = r4_addr;

    a_eval_addr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r2_vld && (r2_req.kind == REQ_EVAL) |-> 32'(n3_addr) < 32'(nint))
        else $error("interval index left the intervals in use");

    a_clamp_only_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r3_vld && r3_clamped |-> (r3_req.kind == REQ_EVAL) && !r3_beyond)
        else $error("clamp flag on a load or beyond-cutoff item");

endmodule

[design/ppte_cell.sv]
module ppte_cell import ppte_pkg::*; #(
    parameter int MAX_INTERVALS = DEF_MAX_INTERVALS,
    parameter int POWER         = 0
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_active,
    input  logic                                i_valid,
    input  t_item                               i_in,
    input  logic [$clog2(MAX_INTERVALS)-1:0]    i_addr,
    output logic                                o_ready,
    output logic                                o_valid,
    output t_item                               o_out,
    output logic [$clog2(MAX_INTERVALS)-1:0]    o_addr,
    input  logic                                i_ready
);

    localparam int IDX_W = $clog2(MAX_INTERVALS);
    localparam logic signed [5:0] PMUL = 6'(POWER);

    t_q                  r_mem [MAX_INTERVALS];
    logic                r_s1_vld, r_s2_vld;
    t_item               r_s1, r_s2, n_s2;
    logic [IDX_W-1:0]    r_s1_addr, r_s2_addr;
    t_q                  r_coef;
    logic signed [63:0]  r_pv, r_pd;
    logic                rdy_s1, rdy_s2, wr;
    t_q                  q_v, q_d;
    logic signed [63:0]  pa;

    assign rdy_s2  = !r_s2_vld || i_ready;
    assign rdy_s1  = !r_s1_vld || rdy_s2;
    assign o_ready = rdy_s1;

    // coefficient load for this cell's power
    assign wr = i_valid && rdy_s1 && (i_in.kind == REQ_COEF) && i_in.wr_ok &&
                (32'(i_in.term) == 32'(POWER));

    // one horner step, floor rounding of the q16.16 products
    assign q_v = sat64(r_pv >>> 16);
    assign q_d = sat64(r_pd >>> 16);
    assign pa  = 64'($signed(r_coef)) * 64'(PMUL);

    always_comb begin
        n_s2 = r_s1;
        if (i_active && (r_s1.kind == REQ_EVAL)) begin
            n_s2.v = sat64(64'($signed(r_coef)) + 64'($signed(q_v)));
            if (POWER > 0) begin
                n_s2.d = sat64(pa + 64'($signed(q_d)));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            if (rdy_s1) r_s1_vld <= i_valid;
            if (rdy_s2) r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_s1) begin
            r_s1      <= i_in;
            r_s1_addr <= i_addr;
            r_pv      <= 64'($signed(i_in.arg)) * 64'($signed(i_in.v));
            r_pd      <= 64'($signed(i_in.arg)) * 64'($signed(i_in.d));
        end
        if (rdy_s2) begin
            r_s2      <= n_s2;
            r_s2_addr <= r_s1_addr;
        end
    end

    // coefficient bank of this power
    always_ff @(posedge i_clk) begin
        if (wr) r_mem[i_addr] <= i_in.arg;
        if (rdy_s1) r_coef <= r_mem[i_addr];
    end

    assign o_valid = r_s2_vld;
    assign o_out   = r_s2;
    assign o_addr  = r_s2_addr;

endmodule

[design/piecewise_polynomial_table_eval.sv]
// piecewise polynomial table evaluator for a tabulated pair potential
// s_axis carries requests: tuser holds the kind (evaluate, load coefficient,
// load interval start), tdata the slot, term and operand. every request gives
// exactly one m_axis item: energy and slope in tdata, beyond_cutoff and
// index_clamped in tuser. loads and unused kinds return all zeros.
// configuration goes through the apb port, register i at byte address 4*i
// an accepted item passes five front stages (subtract, magnitude, index
// multiply, clamp with the start-store read, offset), then in each coefficient
// cell a bank read with the two products and the saturating adds, then the
// output register before it shows on m_axis
// throughput: one item per cycle while m_axis_tready holds; every stage and cell
// takes a new item each cycle when it is empty or its successor moves on
// reset clears the registers to their defaults and empties the pipeline; the
// coefficient and start stores hold nothing defined until loaded
// when the receiver stalls, items fill the stages behind the output register
// and s_axis_tready drops only once the whole chain is full
module piecewise_polynomial_table_eval import ppte_pkg::*; #(
    parameter int MAX_INTERVALS = DEF_MAX_INTERVALS,
    parameter int MAX_TERMS     = DEF_MAX_TERMS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // apb configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // requests
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // slot_index[7:0], term_index[10:8], operand[42:11]
    input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // energy[31:0], slope[63:32]
    output logic [1:0]  m_axis_tuser    // beyond_cutoff[0], index_clamped[1]
);

    localparam int IDX_W   = $clog2(MAX_INTERVALS);
    localparam int NTERM_W = $clog2(MAX_TERMS + 1);

    t_cfg               r_cfg;
    logic [NTERM_W-1:0] nterm;
    logic               cfg_wr;
    t_req               req;

    // cell chain links: index 0 leaves the front end, MAX_TERMS enters the output
    logic               chain_vld  [MAX_TERMS+1];
    logic               chain_rdy  [MAX_TERMS+1];
    t_item              chain_item [MAX_TERMS+1];
    logic [IDX_W-1:0]   chain_addr [MAX_TERMS+1];

    logic               r_out_vld;
    t_q                 r_energy, r_slope;
    logic               r_beyond, r_clamped;
    logic               rdy_out, res_eval;
    t_item              last;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.range_start    <= '0;
            r_cfg.cutoff         <= '0;
            r_cfg.inv_width      <= 32'd65536;
            r_cfg.term_count     <= 4'd1;
            r_cfg.interval_count <= 9'd1;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_RANGE_START:    r_cfg.range_start    <= pwdata;
                REG_CUTOFF:         r_cfg.cutoff         <= pwdata;
                REG_INV_WIDTH:      r_cfg.inv_width      <= pwdata;
                REG_TERM_COUNT:     r_cfg.term_count     <= pwdata[3:0];
                REG_INTERVAL_COUNT: r_cfg.interval_count <= pwdata[8:0];
                default: ;  // writes past the register list are dropped
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_RANGE_START:    prdata = r_cfg.range_start;
            REG_CUTOFF:         prdata = r_cfg.cutoff;
            REG_INV_WIDTH:      prdata = r_cfg.inv_width;
            REG_TERM_COUNT:     prdata = 32'(r_cfg.term_count);
            REG_INTERVAL_COUNT: prdata = 32'(r_cfg.interval_count);
            default:            prdata = '0;
        endcase
    end

    // terms in use, zero read as one, capped at the cell count
    always_comb begin
        if (r_cfg.term_count == 4'd0) begin
            nterm = NTERM_W'(1);
        end else if (32'(r_cfg.term_count) > 32'(MAX_TERMS)) begin
            nterm = NTERM_W'(MAX_TERMS);
        end else begin
            nterm = NTERM_W'(r_cfg.term_count);
        end
    end

    // ---------------- front end: index, clamp, offset ----------------
    assign req.kind = s_axis_tuser[1:0];
    assign req.slot = s_axis_tdata[7:0];
    assign req.term = s_axis_tdata[10:8];
    assign req.opnd = s_axis_tdata[42:11];

    ppte_front #(
        .MAX_INTERVALS (MAX_INTERVALS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_axis_tvalid),
        .i_req   (req),
        .o_ready (s_axis_tready),
        .o_valid (chain_vld[0]),
        .o_item  (chain_item[0]),
        .o_addr  (chain_addr[0]),
        .i_ready (chain_rdy[0])
    );

    // ---------------- horner chain, highest power first ----------------
    for (genvar k = 0; k < MAX_TERMS; k++) begin : g_cell
        ppte_cell #(
            .MAX_INTERVALS (MAX_INTERVALS),
            .POWER         (MAX_TERMS - 1 - k)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_active (NTERM_W'(MAX_TERMS - 1 - k) < nterm),
            .i_valid  (chain_vld[k]),
            .i_in     (chain_item[k]),
            .i_addr   (chain_addr[k]),
            .o_ready  (chain_rdy[k]),
            .o_valid  (chain_vld[k+1]),
            .o_out    (chain_item[k+1]),
            .o_addr   (chain_addr[k+1]),
            .i_ready  (chain_rdy[k+1])
        );
    end

    // ---------------- output register ----------------
    assign rdy_out              = !r_out_vld || m_axis_tready;
    assign chain_rdy[MAX_TERMS] = rdy_out;
    assign last                 = chain_item[MAX_TERMS];
    // only an in-range evaluate carries numbers
    assign res_eval             = (last.kind == REQ_EVAL) && !last.beyond;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (rdy_out) begin
            r_out_vld <= chain_vld[MAX_TERMS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_out) begin
            r_energy  <= res_eval ? last.v : '0;
            r_slope   <= res_eval ? last.d : '0;
            r_beyond  <= last.beyond;
            r_clamped <= last.clamped;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_slope, r_energy};
    assign m_axis_tuser  = {r_clamped, r_beyond};

    a_beyond_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_beyond |-> (r_energy == '0) && (r_slope == '0) && !r_clamped)
        else $error("beyond-cutoff item carries numbers or a clamp flag");

    a_nterm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (nterm != '0) && (32'(nterm) <= 32'(MAX_TERMS)))
        else $error("terms in use outside the cell count");

endmodule
